// ----- sv/b32e_pkg.sv -----
// Shared types and the symbol alphabet for the base32 encoder core.
// No dependencies; every other file imports this package.
package b32e_pkg;

  localparam int MaxSyms = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [6:0] symbol_char;
    logic       end_of_message;
  } symbol_t;

  // Symbols produced by one byte, first symbol in slot 0
  typedef struct packed {
    logic [MaxSyms-1:0][6:0] chars;
    logic [MaxSyms-1:0]      eom;
    logic [1:0]              count;
  } sym_list_t;

  // Map a 5-bit value onto the alphabet without B, I, O and S
  function automatic logic [6:0] b32e_char(input logic [4:0] v);
    logic [6:0] c;
    case (v)
      5'd0:  c = 7'h30;
      5'd1:  c = 7'h31;
      5'd2:  c = 7'h32;
      5'd3:  c = 7'h33;
      5'd4:  c = 7'h34;
      5'd5:  c = 7'h35;
      5'd6:  c = 7'h36;
      5'd7:  c = 7'h37;
      5'd8:  c = 7'h38;
      5'd9:  c = 7'h39;
      5'd10: c = 7'h41; // A
      5'd11: c = 7'h43; // C
      5'd12: c = 7'h44; // D
      5'd13: c = 7'h45; // E
      5'd14: c = 7'h46; // F
      5'd15: c = 7'h47; // G
      5'd16: c = 7'h48; // H
      5'd17: c = 7'h4A; // J
      5'd18: c = 7'h4B; // K
      5'd19: c = 7'h4C; // L
      5'd20: c = 7'h4D; // M
      5'd21: c = 7'h4E; // N
      5'd22: c = 7'h50; // P
      5'd23: c = 7'h51; // Q
      5'd24: c = 7'h52; // R
      5'd25: c = 7'h54; // T
      5'd26: c = 7'h55; // U
      5'd27: c = 7'h56; // V
      5'd28: c = 7'h57; // W
      5'd29: c = 7'h58; // X
      5'd30: c = 7'h59; // Y
      default: c = 7'h5A; // Z
    endcase
    return c;
  endfunction

endpackage

// ----- sv/b32e_symbolize.sv -----
// Combinational split of one byte into up to three alphabet symbols.
// Depends on b32e_pkg; state registers live in the top level.
module b32e_symbolize
  import b32e_pkg::*;
(
  input  item_t      item,
  input  logic [2:0] bit_offset,
  input  logic [3:0] leftover_bits,
  output sym_list_t  syms,
  output logic [2:0] bit_offset_next,
  output logic [3:0] leftover_bits_next
);

  logic [4:0] val0;
  logic [4:0] val1;
  logic [1:0] base_cnt;
  logic       has_left;
  logic [3:0] left;
  logic [2:0] off_after;
  logic [7:0] b;
  logic [3:0] lo;

  assign b  = item.data_byte;
  assign lo = leftover_bits;

  // Pick the full symbols and the bits left over for each starting offset
  always_comb begin
    val0      = b[7:3];
    val1      = 5'd0;
    base_cnt  = 2'd1;
    has_left  = 1'b1;
    left      = {1'b0, b[2:0]};
    off_after = 3'd5;
    case (bit_offset)
      3'd4: begin
        val0      = {b[7], lo[3:0]};
        val1      = b[6:2];
        base_cnt  = 2'd2;
        left      = {2'b00, b[1:0]};
        off_after = 3'd6;
      end
      3'd5: begin
        val0      = {b[7:6], lo[2:0]};
        val1      = b[5:1];
        base_cnt  = 2'd2;
        left      = {3'b000, b[0]};
        off_after = 3'd7;
      end
      3'd6: begin
        val0      = {b[7:5], lo[1:0]};
        val1      = b[4:0];
        base_cnt  = 2'd2;
        has_left  = 1'b0;
        left      = 4'd0;
        off_after = 3'd0;
      end
      3'd7: begin
        val0      = {b[7:4], lo[0]};
        left      = b[3:0];
        off_after = 3'd4;
      end
      default: begin
        // Offsets below four: nothing is waiting
      end
    endcase
  end

  // Append the flush symbol on the last byte and mark the final symbol
  always_comb begin
    logic flush;
    flush = item.last_byte && has_left;
    syms.chars[0] = b32e_char(val0);
    syms.chars[1] = b32e_char(base_cnt == 2'd2 ? val1 : {1'b0, left});
    syms.chars[2] = b32e_char({1'b0, left});
    syms.count    = base_cnt + {1'b0, flush};
    syms.eom      = '0;
    if (item.last_byte) begin
      case (syms.count)
        2'd1:    syms.eom[0] = 1'b1;
        2'd2:    syms.eom[1] = 1'b1;
        default: syms.eom[2] = 1'b1;
      endcase
    end
    if (item.last_byte) begin
      bit_offset_next    = 3'd0;
      leftover_bits_next = 4'd0;
    end else begin
      bit_offset_next    = off_after;
      leftover_bits_next = left;
    end
  end

endmodule

// ----- sv/b32e_emitter.sv -----
// Result buffer: one byte's symbols, out one a cycle while symbol_ready is high.
// Depends on b32e_pkg.
module b32e_emitter
  import b32e_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load_valid,
  output logic      load_ready,
  input  sym_list_t load_syms,
  output logic      symbol_valid,
  input  logic      symbol_ready,
  output symbol_t   symbol
);

  logic [MaxSyms-1:0][6:0] chars;
  logic [MaxSyms-1:0]      eom;
  logic [1:0]              remaining;
  logic                    busy;
  logic                    fire;

  assign fire         = busy && symbol_ready;
  assign load_ready   = !busy || (symbol_ready && remaining == 2'd1);
  assign symbol_valid = busy;
  assign symbol.symbol_char    = chars[0];
  assign symbol.end_of_message = eom[0];

  // Load when idle or as the last symbol leaves; else shift on each word taken
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      remaining <= 2'd0;
    end else if (load_valid && load_ready) begin
      busy      <= 1'b1;
      remaining <= load_syms.count;
      chars     <= load_syms.chars;
      eom       <= load_syms.eom;
    end else if (fire) begin
      if (remaining == 2'd1) begin
        busy <= 1'b0;
      end
      remaining <= remaining - 2'd1;
      chars     <= {7'd0, chars[MaxSyms-1:1]};
      eom       <= {1'b0, eom[MaxSyms-1:1]};
    end
  end

endmodule

// ----- sv/base32_custom_encoder_core.sv -----
// Top level of the streaming base32 encoder: input register, bit state, emitter.
// Depends on b32e_pkg, b32e_symbolize and b32e_emitter.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+-------------------------------
//   item     | item_valid / item_ready      | item_t   (data_byte, last_byte)
//   symbol   | symbol_valid / symbol_ready  | symbol_t (symbol_char, eom)
//
// A byte produces one or two symbols when it is a middle byte
// (eight symbols per five bytes in steady state), up to three on a last byte
// with a flush; the single-word symbol output carries them one at a time.
// The input register takes a new byte while the emitter still drains the last.
// An accepted byte passes the input register, then the emitter buffer, to the output.
// Synchronous reset clears the bit offset, leftover bits and all valid flags.
module base32_custom_encoder_core
  import b32e_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    symbol_valid,
  input  logic    symbol_ready,
  output symbol_t symbol
);

  item_t      hold;
  logic       hold_valid;
  logic [2:0] bit_offset;
  logic [3:0] leftover_bits;
  logic [2:0] bit_offset_next;
  logic [3:0] leftover_bits_next;
  sym_list_t  syms;
  logic       load_ready;
  logic       move;

  assign move       = hold_valid && load_ready;
  assign item_ready = !hold_valid || load_ready;

  // Hold the accepted byte until the emitter takes its symbols
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_ready) begin
      hold_valid <= item_valid;
    end
    if (item_ready && item_valid) begin
      hold <= item;
    end
  end

  // Advance the bit state when a byte moves to the emitter
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_offset    <= 3'd0;
      leftover_bits <= 4'd0;
    end else if (move) begin
      bit_offset    <= bit_offset_next;
      leftover_bits <= leftover_bits_next;
    end
  end

  b32e_symbolize u_symbolize (
    .item               (hold),
    .bit_offset         (bit_offset),
    .leftover_bits      (leftover_bits),
    .syms               (syms),
    .bit_offset_next    (bit_offset_next),
    .leftover_bits_next (leftover_bits_next)
  );

  b32e_emitter u_emitter (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (hold_valid),
    .load_ready   (load_ready),
    .load_syms    (syms),
    .symbol_valid (symbol_valid),
    .symbol_ready (symbol_ready),
    .symbol       (symbol)
  );

endmodule

// ----- tb/sv/tb_base32_custom_encoder_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for base32_custom_encoder_core: random and directed
// byte messages, a bit-level encoder model, and randomized valid/ready gaps.
// Depends on b32e_pkg and the encoder core RTL.
module tb_base32_custom_encoder_core;
  import b32e_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int RandomItems = 348;
  localparam int MaxReports = 10;
  // Alphabet without B, I, O and S, first character in the top byte
  localparam logic [8*32-1:0] AlphaStr = "0123456789ACDEFGHJKLMNPQRTUVWXYZ";

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    symbol_valid;
  logic    symbol_ready = 1'b0;
  symbol_t symbol;

  item_t   byte_q[$];
  symbol_t sym_exp_q[$];

  // Encoder state as the model sees it
  logic [2:0] enc_offset = '0;
  logic [3:0] enc_left = '0;

  int  in_wait = 0;
  int  out_wait = 0;
  int  idle_cycles = 0;
  int  cycle_cnt = 0;
  int  fail_cnt = 0;
  bit  no_idle = 1'b0;

  base32_custom_encoder_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .symbol_valid (symbol_valid),
    .symbol_ready (symbol_ready),
    .symbol       (symbol)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic symbol_t make_sym(input int v);
    symbol_t s;
    s.symbol_char = AlphaStr[8*(31 - (v & 31)) +: 7];
    s.end_of_message = 1'b0;
    return s;
  endfunction

  // Compute the symbols one input word produces and queue them in order
  function automatic void encode_byte(input item_t it);
    symbol_t syms [0:2];
    int b, o, lo_n, hi_n, v, n;
    b = it.data_byte;
    n = 0;
    // Finish the symbol that spans from the previous byte
    if (enc_offset >= 3'd4) begin
      lo_n = 8 - int'(enc_offset);
      hi_n = int'(enc_offset) - 3;
      v = (int'(enc_left) & ((1 << lo_n) - 1)) | ((b >> (8 - hi_n)) << lo_n);
      syms[n] = make_sym(v);
      n++;
      o = hi_n;
    end else begin
      o = 0;
    end
    while (o <= 3) begin
      if (o == 3) begin
        syms[n] = make_sym(b & 31);
        o = 8;
      end else begin
        syms[n] = make_sym((b >> (3 - o)) & 31);
        o += 5;
      end
      n++;
    end
    if (o == 8) begin
      enc_offset = '0;
      enc_left = '0;
    end else if (it.last_byte) begin
      // Flush the leftover bits right aligned
      syms[n] = make_sym(b & ((1 << (8 - o)) - 1));
      n++;
    end else begin
      enc_offset = 3'(o);
      enc_left = 4'(b & ((1 << (8 - o)) - 1));
    end
    if (it.last_byte) begin
      syms[n-1].end_of_message = 1'b1;
      enc_offset = '0;
      enc_left = '0;
    end
    for (int i = 0; i < n; i++) sym_exp_q.push_back(syms[i]);
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic l);
    item_t t;
    t.data_byte = b;
    t.last_byte = l;
    byte_q.push_back(t);
  endfunction

  function automatic logic [7:0] rand_byte();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Switch between stretches with gaps and stretches at full rate
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 256 == 0) no_idle <= ($urandom_range(0, 2) == 0);
  end

  // Drive input words from the pending queue, predict on each accept
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      in_wait <= 0;
    end else begin
      if (item_valid && item_ready) encode_byte(item);
      if (!item_valid || item_ready) begin
        if (in_wait != 0) begin
          item_valid <= 1'b0;
          in_wait <= in_wait - 1;
        end else if (byte_q.size() != 0) begin
          item <= byte_q.pop_front();
          item_valid <= 1'b1;
          in_wait <= no_idle ? 0 : $urandom_range(0, 6);
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Check each accepted output word against the oldest expectation
  always @(posedge clk) begin
    symbol_t exp_sym;
    int w;
    if (rst) begin
      symbol_ready <= 1'b0;
      out_wait <= 0;
    end else begin
      if (symbol_valid && symbol_ready) begin
        if (sym_exp_q.size() == 0) begin
          if (fail_cnt < MaxReports)
            $display("%0t: unexpected symbol char %h eom %b", $realtime,
                     symbol.symbol_char, symbol.end_of_message);
          fail_cnt <= fail_cnt + 1;
        end else begin
          exp_sym = sym_exp_q.pop_front();
          if (symbol.symbol_char !== exp_sym.symbol_char ||
              symbol.end_of_message !== exp_sym.end_of_message) begin
            if (fail_cnt < MaxReports)
              $display("%0t: symbol mismatch: expected char %h eom %b, got char %h eom %b",
                       $realtime, exp_sym.symbol_char, exp_sym.end_of_message,
                       symbol.symbol_char, symbol.end_of_message);
            fail_cnt <= fail_cnt + 1;
          end
        end
        w = no_idle ? 0 : $urandom_range(0, 6);
        out_wait <= w;
        symbol_ready <= (w == 0);
      end else if (out_wait != 0) begin
        out_wait <= out_wait - 1;
        symbol_ready <= (out_wait == 1);
      end else begin
        symbol_ready <= 1'b1;
      end
    end
  end

  // Count cycles in which no word moves on either side
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((item_valid && item_ready) || (symbol_valid && symbol_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int total, len;
    // Single-byte messages at the extremes: one symbol plus a flush
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    // Messages of two to five bytes end on every bit offset; five bytes
    // end exactly on a symbol boundary with nothing to flush
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'hA5, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hFE, 1'b0);
    push_byte(8'h00, 1'b1);
    // Six bytes: wrap past a clean boundary into a second group
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b0);
    push_byte(8'h78, 1'b0);
    push_byte(8'h9A, 1'b0);
    push_byte(8'hBC, 1'b1);

    // Random messages, mostly short, some long
    total = 0;
    while (total < RandomItems) begin
      case ($urandom_range(0, 9))
        0:       len = 1;
        1, 2:    len = $urandom_range(9, 24);
        default: len = $urandom_range(1, 8);
      endcase
      for (int i = 0; i < len; i++) push_byte(rand_byte(), i == len - 1);
      total += len;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Drain: all input words accepted, then every expected symbol seen
    while (byte_q.size() != 0 || item_valid || sym_exp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_cnt == 0 && sym_exp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
